@@ design/u16u8_pkg.sv @@
// Package for the UTF-16 to UTF-8 transcoder: job type between front and back,
// surrogate range constants and the UTF-8 byte encoder.
// No dependencies.
`timescale 1ns / 1ps

package u16u8_pkg;

  localparam logic [15:0] SurrHiMin = 16'hD800;
  localparam logic [15:0] SurrHiMax = 16'hDBFF;
  localparam logic [15:0] SurrLoMin = 16'hDC00;
  localparam logic [15:0] SurrLoMax = 16'hDFFF;
  localparam logic [20:0] SuppBase  = 21'h10000;
  localparam logic [2:0]  MaxBytes  = 3'd6;

  // One job per item that yields bytes: an optional flushed high surrogate
  // (always 3 bytes), then an optional code point.
  typedef struct packed {
    logic        flush;
    logic [15:0] flush_unit;
    logic        main;
    logic [20:0] cp;
  } u16u8_job_t;

  // UTF-8 bytes of one code point, first byte in the low bits
  function automatic logic [31:0] enc_bytes(input logic [20:0] cp);
    logic [31:0] b;
    b = '0;
    if (cp < 21'h80) begin
      b[7:0] = cp[7:0];
    end else if (cp < 21'h800) begin
      b[7:0]  = {3'b110, cp[10:6]};
      b[15:8] = {2'b10, cp[5:0]};
    end else if (cp < SuppBase) begin
      b[7:0]   = {4'b1110, cp[15:12]};
      b[15:8]  = {2'b10, cp[11:6]};
      b[23:16] = {2'b10, cp[5:0]};
    end else begin
      b[7:0]   = {5'b11110, cp[20:18]};
      b[15:8]  = {2'b10, cp[17:12]};
      b[23:16] = {2'b10, cp[11:6]};
      b[31:24] = {2'b10, cp[5:0]};
    end
    return b;
  endfunction

  function automatic logic [2:0] enc_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp < 21'h80) begin
      n = 3'd1;
    end else if (cp < 21'h800) begin
      n = 3'd2;
    end else if (cp < SuppBase) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

@@ design/utf16_to_utf8_transcoder_core.sv @@
// Top level of the UTF-16 to UTF-8 transcoder: front end, job queue, back end.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
//
//  channel | dir | tdata              | tlast
//  s_*     | in  | [15:0] code_unit   | buffer_end
//  m_*     | out | [7:0]  out_byte    | last_of_run
//
// The front takes one code unit per cycle while the two-entry queue has room.
// The back sends one byte per cycle while m_tready allows; an item yields 0 to 6
// bytes, so sustained rate is set by the byte serializer.
// Synchronous reset clears held-surrogate, stop, queue and back-end byte state.
// m_tready low stalls the back; the queue then fills and s_tready drops.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] code_unit
  input  logic        s_tlast,   // buffer_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast    // last_of_run
);
  import u16u8_pkg::*;

  u16u8_job_t f_job, q_job;
  logic       f_valid, q_room, q_valid, q_pop;

  u16u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .unit      (s_tdata),
    .buf_end   (s_tlast),
    .job_valid (f_valid),
    .job_ready (q_room),
    .job       (f_job)
  );

  u16u8_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid),
    .can_push   (q_room),
    .push_job   (f_job),
    .head_valid (q_valid),
    .pop        (q_pop),
    .head_job   (q_job)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_pop   (q_pop),
    .job       (q_job),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

@@ design/u16u8_front.sv @@
// Front end: accepts code units, tracks held surrogate and stop-after-NUL
// state, and issues one byte job per item that yields output. Uses u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          unit,
  input  logic                 buf_end,
  output logic                 job_valid,
  input  logic                 job_ready,
  output u16u8_pkg::u16u8_job_t job
);
  import u16u8_pkg::*;

  logic        holding, holding_next;
  logic        stopped, stopped_next;
  logic [15:0] held;
  logic        hold_load;
  logic        accept;
  logic        is_low, is_high;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;
  assign is_low   = (unit >= SurrLoMin) && (unit <= SurrLoMax);
  assign is_high  = (unit >= SurrHiMin) && (unit <= SurrHiMax);

  always_comb begin
    holding_next   = holding;
    stopped_next   = stopped;
    hold_load      = 1'b0;
    job.flush      = 1'b0;
    job.flush_unit = held;
    job.main       = 1'b0;
    job.cp         = {5'd0, unit};
    if (stopped) begin
      stopped_next = !buf_end;
    end else begin
      holding_next = 1'b0;
      if (holding && is_low) begin
        // surrogate pair
        job.main = 1'b1;
        job.cp   = SuppBase + {1'b0, held[9:0], unit[9:0]};
      end else begin
        job.flush = holding;
        if (unit == 16'd0) begin
          stopped_next = !buf_end;
        end else if (is_high && !buf_end) begin
          hold_load    = 1'b1;
          holding_next = 1'b1;
        end else begin
          job.main = 1'b1;
        end
      end
    end
  end

  assign job_valid = accept && (job.flush || job.main);

  always_ff @(posedge clk) begin
    if (rst) begin
      holding <= 1'b0;
      stopped <= 1'b0;
    end else if (accept) begin
      holding <= holding_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_load) begin
      held <= unit;
    end
  end

endmodule

@@ design/u16u8_queue.sv @@
// Two-entry job queue between front and back ends.
// Uses u16u8_pkg for the job type.
`timescale 1ns / 1ps

module u16u8_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 can_push,
  input  u16u8_pkg::u16u8_job_t push_job,
  output logic                 head_valid,
  input  logic                 pop,
  output u16u8_pkg::u16u8_job_t head_job
);
  import u16u8_pkg::*;

  u16u8_job_t entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign can_push   = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

@@ design/u16u8_back.sv @@
// Back end: expands a job into up to six UTF-8 bytes and sends them one per
// cycle, while out_ready allows, through a registered output. Uses u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_pop,
  input  u16u8_pkg::u16u8_job_t job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_data,
  output logic                 out_last
);
  import u16u8_pkg::*;

  logic [47:0] bytes;
  logic [2:0]  rem;
  logic        emit, load;
  logic [31:0] flush_b, main_b;
  logic [2:0]  main_len;
  logic [47:0] new_bytes;
  logic [2:0]  new_len;

  always_comb begin
    flush_b  = enc_bytes({5'd0, job.flush_unit});
    main_b   = enc_bytes(job.cp);
    main_len = job.main ? enc_len(job.cp) : 3'd0;
    if (job.flush) begin
      // a unit after a flushed surrogate is never a pair, so at most 3 bytes
      new_bytes = {main_b[23:0], flush_b[23:0]};
      new_len   = main_len + 3'd3;
    end else begin
      new_bytes = {16'd0, main_b};
      new_len   = main_len;
    end
  end

  assign emit    = (rem != 3'd0) && (!out_valid || out_ready);
  assign load    = job_valid && ((rem == 3'd0) || (emit && rem == 3'd1));
  assign job_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        rem <= new_len;
      end else if (emit) begin
        rem <= rem - 3'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= new_bytes;
    end else if (emit) begin
      bytes <= {8'd0, bytes[47:8]};
    end
    if (emit) begin
      out_data <= bytes[7:0];
      out_last <= (rem == 3'd1);
    end
  end

`ifndef SYNTH
  a_load_nonempty: assert property (@(posedge clk) disable iff (rst)
    load |=> rem != 3'd0)
    else $error("job loaded with no bytes");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> rem <= MaxBytes)
    else $error("byte count out of range");
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid && (out_last == ($past(rem) == 3'd1)))
    else $error("last flag does not match final byte");
`endif

endmodule

@@ sim/tb.sv @@
// Testbench for utf16_to_utf8_transcoder_core: UTF-16 units drive the slave stream,
// UTF-8 bytes are checked against a local transcoding predictor in a scoreboard class.
// Depends on the RTL in design/ only; no package items are needed by the ports.
`timescale 1ns / 1ps

typedef struct {
  logic [7:0] value;
  logic       last;
} utf8_byte_t;

class utf8_scoreboard;
  localparam logic [15:0] HiMin = 16'hD800;
  localparam logic [15:0] HiMax = 16'hDBFF;
  localparam logic [15:0] LoMin = 16'hDC00;
  localparam logic [15:0] LoMax = 16'hDFFF;

  logic [15:0] held_hi;
  bit          holding;
  bit          stopped;
  utf8_byte_t  expected_bytes[$];
  int          mismatches;
  int          bytes_checked;
  int          units_taken;
  int          units_ignored;
  int          pairs_joined;
  int          lone_flushes;

  function new();
    held_hi = '0;
    holding = 1'b0;
    stopped = 1'b0;
  endfunction

  function void flag_error(string what, logic [8:0] exp_v, logic [8:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $time, what, exp_v[7:0], exp_v[8], act_v[7:0], act_v[8]);
  endfunction

  // append the UTF-8 form of one code point to a run
  function void encode_point(logic [20:0] cp, ref utf8_byte_t run[$]);
    utf8_byte_t b;
    b.last = 1'b0;
    if (cp < 21'h80) begin
      b.value = cp[7:0];
      run = {run, b};
    end else if (cp < 21'h800) begin
      b.value = {3'b110, cp[10:6]};  run = {run, b};
      b.value = {2'b10, cp[5:0]};    run = {run, b};
    end else if (cp < 21'h10000) begin
      b.value = {4'b1110, cp[15:12]}; run = {run, b};
      b.value = {2'b10, cp[11:6]};    run = {run, b};
      b.value = {2'b10, cp[5:0]};     run = {run, b};
    end else begin
      b.value = {5'b11110, cp[20:18]}; run = {run, b};
      b.value = {2'b10, cp[17:12]};    run = {run, b};
      b.value = {2'b10, cp[11:6]};     run = {run, b};
      b.value = {2'b10, cp[5:0]};      run = {run, b};
    end
  endfunction

  function void note_unit(logic [15:0] unit, logic buf_end);
    utf8_byte_t run[$];
    bit         consumed;
    consumed = 1'b0;
    units_taken++;
    // after a NUL everything up to the buffer end is dropped
    if (stopped) begin
      units_ignored++;
      if (buf_end)
        stopped = 1'b0;
      return;
    end
    if (holding) begin
      holding = 1'b0;
      if (unit >= LoMin && unit <= LoMax) begin
        encode_point(21'h10000 + {1'b0, held_hi[9:0], unit[9:0]}, run);
        pairs_joined++;
        consumed = 1'b1;
      end else begin
        encode_point({5'd0, held_hi}, run);
        lone_flushes++;
      end
      held_hi = '0;
    end
    if (!consumed) begin
      if (unit == 16'h0000) begin
        stopped = !buf_end;
      end else if (unit >= HiMin && unit <= HiMax && !buf_end) begin
        held_hi = unit;
        holding = 1'b1;
      end else begin
        encode_point({5'd0, unit}, run);
      end
    end
    if (run.size() > 0)
      run[run.size() - 1].last = 1'b1;
    expected_bytes = {expected_bytes, run};
  endfunction

  function void check_byte(logic [7:0] value, logic last);
    utf8_byte_t exp_b;
    bytes_checked++;
    if (expected_bytes.size() == 0) begin
      flag_error("byte with nothing expected", 9'h000, {last, value});
      return;
    end
    exp_b = expected_bytes.pop_front();
    if (value !== exp_b.value || last !== exp_b.last)
      flag_error("byte mismatch", {exp_b.last, exp_b.value}, {last, value});
  endfunction

  function int pending();
    return expected_bytes.size();
  endfunction
endclass

module tb;
  localparam int CycleLimit   = 200000;
  localparam int RandomUnits  = 250;
  localparam int LongHold     = 250;
  localparam int DrainCycles  = 30;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [15:0] code_unit
  logic        s_tlast;   // buffer_end
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] out_byte
  logic        m_tlast;   // last_of_run

  utf8_scoreboard sb = new();
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  long_hold_req = 1'b0;

  utf16_to_utf8_transcoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycle_count, sb.pending());
      $display("[utf16_to_utf8_transcoder_core] ERROR");
      $finish;
    end
  end

  // one place samples both handshakes, input first, so same-edge results are predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_unit(s_tdata, s_tlast);
      if (m_tvalid && m_tready)
        sb.check_byte(m_tdata, m_tlast);
    end
  end

  // receiver: segments of assorted stall patterns, plus one long hold on request
  initial begin : rx_side
    int mode;
    int seg_len;
    m_tready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        repeat (LongHold) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        mode    = $urandom_range(0, 4);
        seg_len = $urandom_range(8, 60);
        for (int k = 0; k < seg_len; k++) begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (k % 4 != 3);
            3:       m_tready <= (k % 3 == 0);
            default: m_tready <= ($urandom_range(0, 9) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_unit(input logic [15:0] unit, input logic buf_end);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= unit;
    s_tlast  <= buf_end;
    do @(posedge clk); while (s_tready !== 1'b1);
  endtask

  // first clear valid and wait past the handshake edge, so the last accepted unit is already in the scoreboard
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_unit(int kind);
    logic [15:0] u;
    case (kind)
      0: u = 16'($urandom_range(16'h0001, 16'h007F));
      1: u = 16'($urandom_range(16'h0080, 16'h07FF));
      2: begin
        u = 16'($urandom_range(16'h0800, 16'hF7FF));
        if (u >= 16'hD800) u = u + 16'h0800;   // skip the surrogate range
      end
      3: u = 16'($urandom_range(16'hD800, 16'hDBFF));
      4: u = 16'($urandom_range(16'hDC00, 16'hDFFF));
      default: u = 16'($urandom_range(0, 16'hFFFF));
    endcase
    return u;
  endfunction

  // each entry: {buffer_end, code_unit}
  logic [16:0] directed_units[] = '{
    {1'b0, 16'h0041}, {1'b0, 16'h007F}, {1'b0, 16'h0080}, {1'b0, 16'h07FF},
    {1'b0, 16'h0800}, {1'b0, 16'hFFFF},
    {1'b0, 16'hD800}, {1'b0, 16'hDC00},                     // lowest pair
    {1'b0, 16'hDBFF}, {1'b0, 16'hDFFF},                     // highest pair
    {1'b0, 16'hD834}, {1'b0, 16'h0041},                     // held high flushed
    {1'b0, 16'hD800}, {1'b0, 16'hD801}, {1'b1, 16'hDC01},   // high after high, pair at end
    {1'b1, 16'hDBFF},                                       // high on buffer end
    {1'b0, 16'hDC00},                                       // lone low
    {1'b0, 16'hD900}, {1'b0, 16'h0000},                     // NUL flushes and stops
    {1'b0, 16'h0041}, {1'b1, 16'hFFFF},                     // dropped up to buffer end
    {1'b1, 16'h0000},                                       // NUL on buffer end
    {1'b0, 16'h0001}, {1'b0, 16'hD800}, {1'b1, 16'hFFFF}    // held flushed at end
  };

  initial begin : stimulus
    int          kind;
    int          buf_len;
    int          active_units;
    bit          hold_done;
    bit          pause_done;
    logic [15:0] unit_q[$];

    hold_done  = 1'b0;
    pause_done = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_units[i])
      send_unit(directed_units[i][15:0], directed_units[i][16]);
    wait_drained();

    // random buffers, mostly well-formed text with some noise and a rare NUL
    active_units = 0;
    while (active_units < RandomUnits) begin
      buf_len = $urandom_range(1, 10);
      unit_q.delete();
      while (unit_q.size() < buf_len) begin
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
          unit_q = {unit_q, pick_unit(0)};
        end else if (kind < 40) begin
          unit_q = {unit_q, pick_unit(1)};
        end else if (kind < 55) begin
          unit_q = {unit_q, pick_unit(2)};
        end else if (kind < 75) begin
          unit_q = {unit_q, pick_unit(3)};
          unit_q = {unit_q, pick_unit(4)};
        end else if (kind < 82) begin
          unit_q = {unit_q, pick_unit(3)};
        end else if (kind < 88) begin
          unit_q = {unit_q, pick_unit(4)};
        end else if (kind < 90) begin
          unit_q = {unit_q, 16'h0000};
        end else begin
          unit_q = {unit_q, pick_unit(5)};
        end
      end
      foreach (unit_q[i])
        send_unit(unit_q[i], i == unit_q.size() - 1);
      active_units = sb.units_taken - sb.units_ignored - directed_units.size();
      if (!hold_done && active_units > 80) begin
        hold_done = 1'b1;
        long_hold_req = 1'b1;
      end
      if (!pause_done && active_units > 180) begin
        pause_done = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    if (sb.pending() != 0)
      $display("%0d expected bytes never arrived", sb.pending());
    $display("units sent %0d (%0d dropped after NUL), pairs joined %0d, lone highs flushed %0d",
             sb.units_taken, sb.units_ignored, sb.pairs_joined, sb.lone_flushes);
    $display("bytes checked %0d, mismatches %0d", sb.bytes_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("[utf16_to_utf8_transcoder_core] OK");
    else
      $display("[utf16_to_utf8_transcoder_core] ERROR");
    $finish;
  end
endmodule

@@ utf16_to_utf8_transcoder_core.f @@
design/u16u8_pkg.sv
design/u16u8_front.sv
design/u16u8_queue.sv
design/u16u8_back.sv
design/utf16_to_utf8_transcoder_core.sv
sim/tb.sv
